// ----- sv/clsr_pkg.sv -----
package clsr_pkg;

    localparam int unsigned GEN_W  = 31;
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned PROD_W = GEN_W + MUL_W;

    localparam logic [30:0] MOD_ONE  = 31'd2147483563;
    localparam logic [30:0] MOD_TWO  = 31'd2147483399;
    localparam logic [15:0] MUL_ONE  = 16'd40014;
    localparam logic [15:0] MUL_TWO  = 16'd40692;
    localparam logic [7:0]  FOLD_ONE = 8'd85;
    localparam logic [7:0]  FOLD_TWO = 8'd249;
    localparam logic [30:0] FOLD_ADD = 31'd2147483562;
    localparam logic [30:0] SECOND_RESET = 31'd123456789;
    localparam int unsigned WARMUP = 8;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef struct packed {
        logic seed_load;
        logic seed_mul;
        logic seed_red;
        logic draw_start;
        logic draw_addr;
        logic draw_commit;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
    } t_sts;

endpackage

// ----- sv/combined_lcg_shuffle_rng.sv -----
// Channel   Dir  Ports                                         Bits
// request   in   i_in_valid/o_in_ready, i_cmd, i_seed_value     1, 31
// deviate   out  o_out_valid/i_out_ready, o_deviate             31
//
// A draw multiplies on the accepting edge, then reduces and reads the shuffle table,
// then combines and writes back, which makes the deviate valid; the next request is
// accepted after that commit. A seed request steps generator one through warm-up and
// table fill, each step a multiply and a reduce through the same modular unit, then draws.
// A waiting deviate holds the next request in its combine stage until taken.
// Synchronous active-low reset; the table reads as zero until written.
module combined_lcg_shuffle_rng #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [30:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [30:0] o_deviate
);

    clsr_pkg::t_cmd ctl;
    clsr_pkg::t_sts sts;

    clsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    clsr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_seed_value (i_seed_value),
        .o_deviate    (o_deviate)
    );

endmodule

// ----- sv/clsr_ram.sv -----
module clsr_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/clsr_ctrl.sv -----
module clsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_cmd,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clsr_pkg::t_cmd  o_ctl,
    input  clsr_pkg::t_sts  i_sts
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_SEED_MUL   = 3'd1;
    localparam logic [2:0] S_SEED_RED   = 3'd2;
    localparam logic [2:0] S_DRAW_START = 3'd3;
    localparam logic [2:0] S_DRAW_ADDR  = 3'd4;
    localparam logic [2:0] S_DRAW_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;
    logic       accept;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == clsr_pkg::CMD_SEED) begin
                        o_ctl.seed_load = 1'b1;
                        n_state = S_SEED_MUL;
                    end else begin
                        o_ctl.draw_start = 1'b1;
                        n_state = S_DRAW_ADDR;
                    end
                end
            end
            S_SEED_MUL: begin
                o_ctl.seed_mul = 1'b1;
                n_state = S_SEED_RED;
            end
            S_SEED_RED: begin
                o_ctl.seed_red = 1'b1;
                n_state = i_sts.idx_zero ? S_DRAW_START : S_SEED_MUL;
            end
            S_DRAW_START: begin
                o_ctl.draw_start = 1'b1;
                n_state = S_DRAW_ADDR;
            end
            S_DRAW_ADDR: begin
                o_ctl.draw_addr = 1'b1;
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (out_free) begin
                    o_ctl.draw_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_ctl.draw_commit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ----- sv/clsr_dp.sv -----
module clsr_dp #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clsr_pkg::t_cmd  i_ctl,
    output clsr_pkg::t_sts  o_sts,
    input  logic [30:0]     i_seed_value,
    output logic [30:0]     o_deviate
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned QW = $clog2(TABLE_DEPTH + 2);
    localparam int unsigned IW = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP);
    localparam int unsigned XW = 31 + QW;
    localparam logic [30:0] SLOT_DIV =
        31'(64'(clsr_pkg::FOLD_ADD) / 64'(TABLE_DEPTH)) + 31'd1;
    localparam logic [QW-1:0] RECIP = QW'(64'h8000_0000 / 64'(SLOT_DIV));
    localparam logic [IW-1:0] IDX_START = IW'(TABLE_DEPTH + clsr_pkg::WARMUP - 1);
    localparam logic [IW-1:0] IDX_DEPTH = IW'(TABLE_DEPTH);
    localparam logic [QW-1:0] Q_DEPTH   = QW'(TABLE_DEPTH);
    localparam logic [AW-1:0] SLOT_MAX  = AW'(TABLE_DEPTH - 1);

    function automatic logic [30:0] mod_reduce(
        input logic [clsr_pkg::PROD_W-1:0] p,
        input logic [7:0]                  fold,
        input logic [30:0]                 modulus
    );
        logic [31:0] s;
        s = 32'(p[clsr_pkg::PROD_W-1:31]) * 32'(fold) + 32'(p[30:0]);
        if (s >= {1'b0, modulus}) begin
            s = s - {1'b0, modulus};
        end
        return s[30:0];
    endfunction

    logic [30:0]                 r_gen1;
    logic [30:0]                 r_gen2;
    logic [30:0]                 r_last;
    logic [clsr_pkg::PROD_W-1:0] r_p1;
    logic [clsr_pkg::PROD_W-1:0] r_p2;
    logic [QW-1:0]               r_q;
    logic [AW-1:0]               r_slot;
    logic [IW-1:0]               r_idx;
    logic [TABLE_DEPTH-1:0]      r_vld;
    logic [30:0]                 r_dev;

    logic [30:0]   seed_clamped;
    logic [30:0]   gen1_next;
    logic [30:0]   gen2_next;
    logic [XW-1:0] q_prod;
    logic [XW-1:0] bound;
    logic [QW-1:0] q_fix;
    logic [AW-1:0] slot;
    logic [30:0]   rdata;
    logic [30:0]   entry;
    logic [31:0]   diff;
    logic [31:0]   diff_fold;
    logic [30:0]   dev;
    logic          idx_in_table;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [30:0]   ram_wdata;

    assign seed_clamped = (i_seed_value == '0) ? 31'd1 : i_seed_value;
    assign gen1_next    = mod_reduce(r_p1, clsr_pkg::FOLD_ONE, clsr_pkg::MOD_ONE);
    assign gen2_next    = mod_reduce(r_p2, clsr_pkg::FOLD_TWO, clsr_pkg::MOD_TWO);

    assign q_prod = XW'(r_last) * XW'(RECIP);
    assign bound  = XW'(r_q + QW'(1)) * XW'(SLOT_DIV);
    assign q_fix  = (XW'(r_last) >= bound) ? (r_q + QW'(1)) : r_q;
    assign slot   = (q_fix >= Q_DEPTH) ? SLOT_MAX : q_fix[AW-1:0];

    assign entry     = r_vld[r_slot] ? rdata : '0;
    assign diff      = {1'b0, entry} - {1'b0, r_gen2};
    assign diff_fold = diff + {1'b0, clsr_pkg::FOLD_ADD};
    assign dev       = (entry > r_gen2) ? diff[30:0] : diff_fold[30:0];

    assign idx_in_table = (r_idx < IDX_DEPTH);
    assign ram_we    = (i_ctl.seed_red && idx_in_table) || i_ctl.draw_commit;
    assign ram_waddr = i_ctl.draw_commit ? r_slot : r_idx[AW-1:0];
    assign ram_wdata = i_ctl.draw_commit ? r_gen1 : gen1_next;

    assign o_sts.idx_zero = (r_idx == '0);
    assign o_deviate      = r_dev;

    clsr_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.draw_addr),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen1 <= 31'd1;
            r_gen2 <= clsr_pkg::SECOND_RESET;
            r_last <= '0;
            r_idx  <= '0;
            r_vld  <= '0;
        end else begin
            if (i_ctl.seed_load) begin
                r_gen1 <= seed_clamped;
                r_gen2 <= seed_clamped;
                r_idx  <= IDX_START;
            end
            if (i_ctl.seed_red) begin
                r_gen1 <= gen1_next;
                if (idx_in_table) begin
                    r_vld[r_idx[AW-1:0]] <= 1'b1;
                end
                if (r_idx == '0) begin
                    r_last <= gen1_next;
                end else begin
                    r_idx <= r_idx - IW'(1);
                end
            end
            if (i_ctl.draw_addr) begin
                r_gen1 <= gen1_next;
                r_gen2 <= gen2_next;
            end
            if (i_ctl.draw_commit) begin
                r_vld[r_slot] <= 1'b1;
                r_last        <= dev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.seed_mul || i_ctl.draw_start) begin
            r_p1 <= clsr_pkg::PROD_W'(r_gen1) * clsr_pkg::PROD_W'(clsr_pkg::MUL_ONE);
        end
        if (i_ctl.draw_start) begin
            r_p2 <= clsr_pkg::PROD_W'(r_gen2) * clsr_pkg::PROD_W'(clsr_pkg::MUL_TWO);
            r_q  <= q_prod[XW-1:31];
        end
        if (i_ctl.draw_addr) begin
            r_slot <= slot;
        end
        if (i_ctl.draw_commit) begin
            r_dev <= dev;
        end
    end

endmodule

// ----- sv/clsr_chk.sv -----
module clsr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [30:0] o_deviate
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_deviate)))
        else $error("deviate dropped or changed while stalled");

    a_dev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_deviate != 31'd0 && o_deviate <= clsr_pkg::FOLD_ADD))
        else $error("deviate out of range");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind combined_lcg_shuffle_rng clsr_chk u_clsr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_deviate   (o_deviate)
);

// ----- tb/tb_combined_lcg_shuffle_rng.sv -----
`timescale 1ns / 1ps

module tb_combined_lcg_shuffle_rng;

    localparam int unsigned DEPTH       = 32;
    localparam int unsigned RAND_ITEMS  = 1630;
    localparam int unsigned PHASE_LEN   = RAND_ITEMS / 4;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'(clsr_pkg::FOLD_ADD) / 64'(DEPTH);

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_cmd;
    logic [30:0] i_seed_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [30:0] o_deviate;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned seeds_sent;
    int unsigned draws_sent;

    combined_lcg_shuffle_rng #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_seed_value (i_seed_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_deviate    (o_deviate)
    );

    class deviate_scoreboard;
        logic [30:0] gen_one;
        logic [30:0] gen_two;
        logic [30:0] prev_dev;
        logic [30:0] shuffle_tbl [DEPTH];
        logic [30:0] deviates_due [$];
        int unsigned failures;
        int unsigned matched;

        function new();
            gen_one  = 31'd1;
            gen_two  = clsr_pkg::SECOND_RESET;
            prev_dev = '0;
            foreach (shuffle_tbl[i]) shuffle_tbl[i] = '0;
            failures = 0;
            matched  = 0;
        endfunction

        function logic [30:0] lcg_one(logic [30:0] x);
            return 31'((64'(clsr_pkg::MUL_ONE) * 64'(x)) % 64'(clsr_pkg::MOD_ONE));
        endfunction

        function logic [30:0] lcg_two(logic [30:0] x);
            return 31'((64'(clsr_pkg::MUL_TWO) * 64'(x)) % 64'(clsr_pkg::MOD_TWO));
        endfunction

        function void reseed(logic [30:0] seed);
            logic [30:0] s;
            s = (seed == '0) ? 31'd1 : seed;
            gen_one = s;
            gen_two = s;
            for (int i = DEPTH + clsr_pkg::WARMUP - 1; i >= 0; i--) begin
                gen_one = lcg_one(gen_one);
                if (i < DEPTH) shuffle_tbl[i] = gen_one;
            end
            prev_dev = shuffle_tbl[0];
        endfunction

        function logic [30:0] draw();
            longint unsigned slot;
            longint mixed;
            gen_one = lcg_one(gen_one);
            gen_two = lcg_two(gen_two);
            slot = 64'(prev_dev) / SLOT_DIV;
            if (slot >= DEPTH) slot = DEPTH - 1;
            mixed = longint'(shuffle_tbl[slot]) - longint'(gen_two);
            shuffle_tbl[slot] = gen_one;
            if (mixed < 1) mixed += longint'(clsr_pkg::FOLD_ADD);
            prev_dev = 31'(mixed);
            return prev_dev;
        endfunction

        function void note_request(logic cmd, logic [30:0] seed);
            if (cmd == clsr_pkg::CMD_SEED) reseed(seed);
            deviates_due.push_back(draw());
        endfunction

        function void check_deviate(logic [30:0] got);
            logic [30:0] want;
            if (deviates_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected deviate: expected none, actual %0d", $time, got);
                return;
            end
            want = deviates_due.pop_front();
            if (got !== want) begin
                failures++;
                $display("%0t: deviate mismatch: expected %0d, actual %0d", $time, want, got);
            end else begin
                matched++;
            end
        endfunction

        function int unsigned pending();
            return deviates_due.size();
        endfunction
    endclass

    deviate_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("** combined_lcg_shuffle_rng: FAILED **");
        $finish;
    end

    task automatic issue_request(input logic cmd, input logic [30:0] seed);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_seed_value <= seed;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(cmd, seed);
        if (cmd == clsr_pkg::CMD_SEED) seeds_sent++;
        else draws_sent++;
    endtask

    task automatic random_request();
        logic [30:0] seed;
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(9))
                0: seed = 31'($urandom_range(15));
                1: seed = 31'($urandom_range(32'h7FFF_FFFF, 32'(clsr_pkg::MOD_TWO)));
                default: seed = 31'($urandom);
            endcase
            issue_request(clsr_pkg::CMD_SEED, seed);
        end else begin
            issue_request(clsr_pkg::CMD_DRAW, 31'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_deviate(o_deviate);
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        int unsigned waited;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        seeds_sent     = 0;
        draws_sent     = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= clsr_pkg::CMD_DRAW;
        i_seed_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // draws straight out of reset, then seeds at the edges of the range
        issue_request(clsr_pkg::CMD_DRAW, 31'h7FFF_FFFF);
        issue_request(clsr_pkg::CMD_DRAW, 31'h0000_0000);
        issue_request(clsr_pkg::CMD_DRAW, 31'h2AAA_AAAA);
        issue_request(clsr_pkg::CMD_SEED, 31'd0);
        issue_request(clsr_pkg::CMD_DRAW, 31'h5555_5555);
        issue_request(clsr_pkg::CMD_SEED, 31'd1);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_SEED, clsr_pkg::FOLD_ADD);
        issue_request(clsr_pkg::CMD_SEED, 31'h7FFF_FFFF);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_SEED, clsr_pkg::MOD_ONE);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_SEED, clsr_pkg::MOD_TWO);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);
        issue_request(clsr_pkg::CMD_SEED, 31'h5555_5555);
        issue_request(clsr_pkg::CMD_SEED, 31'h2AAA_AAAA);
        issue_request(clsr_pkg::CMD_DRAW, 31'h7FFF_FFFF);
        issue_request(clsr_pkg::CMD_SEED, 31'd12345);
        issue_request(clsr_pkg::CMD_DRAW, 31'd0);

        for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
            case (n / PHASE_LEN)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            random_request();
        end
        i_in_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.failures++;
            $display("%0t: %0d deviates never arrived", $time, sb.pending());
        end

        $display("Sent %0d seed and %0d draw requests across four handshake pacing phases;",
                 seeds_sent, draws_sent);
        $display("%0d deviates matched the predictor, %0d failures.", sb.matched, sb.failures);
        if (sb.failures == 0) begin
            $display("** combined_lcg_shuffle_rng: PASSED **");
        end else begin
            $display("** combined_lcg_shuffle_rng: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/clsr_pkg.sv
sv/clsr_ram.sv
sv/clsr_ctrl.sv
sv/clsr_dp.sv
sv/combined_lcg_shuffle_rng.sv
sv/clsr_chk.sv
tb/tb_combined_lcg_shuffle_rng.sv
